/* hw/rtl/mau_pkg.sv */
// Package for the 256-bit modular arithmetic unit: item codes, operation codes,
// sequencer states and fixed primes. No dependencies.
`timescale 1ns / 1ps
package mau_pkg;

  localparam int unsigned OperandBitsDef = 256;
  localparam int unsigned LimbBitsDef    = 64;

  typedef enum logic [1:0] {
    KIND_LOAD_A = 2'd0,
    KIND_LOAD_B = 2'd1,
    KIND_LOAD_M = 2'd2,
    KIND_EXEC   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    OP_MUL25519 = 3'd0,
    OP_MULP256  = 3'd1,
    OP_ADDP     = 3'd2,
    OP_SUBP     = 3'd3,
    OP_MULP     = 3'd4,
    OP_REDP     = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RED,
    ST_RED2,
    ST_FIX,
    ST_EMIT
  } state_e;

  // 2^255 - 19 and 2^256 - 2^224 + 2^192 + 2^96 - 1
  localparam logic [255:0] Prime25519 =
    256'h7FFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFED;
  localparam logic [255:0] PrimeP256 =
    256'hFFFFFFFF_00000001_00000000_00000000_00000000_FFFFFFFF_FFFFFFFF_FFFFFFFF;

  // Control word from the sequencer to the datapath
  typedef struct packed {
    logic step;   // perform one serial step
    logic start;  // capture the source for a new reduction
  } red_ctrl_t;

endpackage

/* hw/rtl/mau_reducer.sv */
// Bit-serial shift-subtract reducer: x mod m, one bit of x per cycle in which step is set.
// Depends on mau_pkg.
`timescale 1ns / 1ps
module mau_reducer import mau_pkg::*; #(
  parameter int unsigned OperandBits = OperandBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  red_ctrl_t                ctrl_i,
  input  logic [2*OperandBits-1:0] x_i,
  input  logic [OperandBits-1:0]   m_i,
  output logic [OperandBits-1:0]   r_o
);

  logic [2*OperandBits-1:0] x_q, x_d;
  logic [OperandBits:0]     r_q, r_d;
  logic [OperandBits+1:0]   sh;
  logic [OperandBits+1:0]   diff;

  always_comb begin
    x_d  = x_q;
    r_d  = r_q;
    sh   = {r_q, x_q[2*OperandBits-1]};
    diff = sh - {2'b00, m_i};
    if (ctrl_i.start) begin
      x_d = x_i;
      r_d = '0;
    end else if (ctrl_i.step) begin
      x_d = {x_q[2*OperandBits-2:0], 1'b0};
      // subtract when the shifted remainder reaches the modulus
      if (!diff[OperandBits+1]) begin
        r_d = diff[OperandBits:0];
      end else begin
        r_d = sh[OperandBits:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= '0;
    end else begin
      r_q <= r_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
  end

  assign r_o = r_q[OperandBits-1:0];

endmodule

/* hw/rtl/mau_multiplier.sv */
// Bit-serial shift-add multiplier: full 2N-bit product, one bit of b per cycle with step_i set.
// Depends on mau_pkg.
`timescale 1ns / 1ps
module mau_multiplier import mau_pkg::*; #(
  parameter int unsigned OperandBits = OperandBitsDef
) (
  input  logic                     clk_i,
  input  logic                     start_i,
  input  logic                     step_i,
  input  logic [OperandBits-1:0]   a_i,
  input  logic [OperandBits-1:0]   b_i,
  output logic [2*OperandBits-1:0] p_o
);

  logic [OperandBits-1:0]   b_q, b_d;
  logic [2*OperandBits-1:0] p_q, p_d;

  always_comb begin
    b_d = b_q;
    p_d = p_q;
    if (start_i) begin
      b_d = b_i;
      p_d = '0;
    end else if (step_i) begin
      // MSB first: double then add
      b_d = {b_q[OperandBits-2:0], 1'b0};
      p_d = {p_q[2*OperandBits-2:0], 1'b0}
          + (b_q[OperandBits-1] ? {{OperandBits{1'b0}}, a_i} : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    b_q <= b_d;
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

/* hw/rtl/modular_arith_unit_256_top.sv */
// Sequence, N = OPERAND_BITS: add and the 2N-bit reduce run 2N reduction steps before the
// first output word, the multiplies run N multiply steps then 2N reduction steps,
// subtract runs two reductions and a fix-up state; a zero modulus goes from ST_MUL
// straight to ST_EMIT. Then NLIMB output words, one per ready cycle.
// One item at a time: input ready only when idle.
// Reset clears the operand and modulus limbs and the sequencer.
`timescale 1ns / 1ps
module modular_arith_unit_256_top import mau_pkg::*; #(
  parameter int unsigned OPERAND_BITS = OperandBitsDef,
  parameter int unsigned LIMB_BITS    = LimbBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [63:0] limb_value, [66:64] operation, [71:67] zero
  input  logic [71:0] s_axis_tdata,
  // [1:0] kind, [3:2] limb_index
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [63:0] result_limb, [65:64] result_index, [71:66] zero
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // [0] error
  output logic        m_axis_tuser
);

  localparam int unsigned NLimbRaw = OPERAND_BITS / LIMB_BITS;
  localparam int unsigned NLimb    = NLimbRaw > 4 ? 4 : NLimbRaw;
  localparam int unsigned N        = OPERAND_BITS;
  localparam int unsigned CntW     = $clog2(2*N+1);

  logic [LIMB_BITS-1:0] a_q [4];
  logic [LIMB_BITS-1:0] b_q [4];
  logic [LIMB_BITS-1:0] m_q [4];
  logic [N-1:0] a_v, b_v, m_v, mod_v;

  kind_e             kind;
  logic [1:0]        lidx;
  logic [2:0]        op_in;
  state_e            st_q, st_d;
  op_e               op_q, op_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [1:0]        oidx_q, oidx_d;
  logic              err_q, err_d;
  logic [N-1:0]      ra_q, ra_d;
  logic [N-1:0]      res_q, res_d;
  logic              mstart, mstep;
  red_ctrl_t         rctrl;
  logic [2*N-1:0]    prod, rsrc;
  logic [N-1:0]      rem;
  logic              accept;
  logic [N:0]        fix_sum;

  assign kind  = kind_e'(s_axis_tuser[1:0]);
  assign lidx  = s_axis_tuser[3:2];
  assign op_in = s_axis_tdata[66:64];

  always_comb begin
    a_v = '0;
    b_v = '0;
    m_v = '0;
    for (int i = 0; i < NLimb; i++) begin
      a_v[i*LIMB_BITS +: LIMB_BITS] = a_q[i];
      b_v[i*LIMB_BITS +: LIMB_BITS] = b_q[i];
      m_v[i*LIMB_BITS +: LIMB_BITS] = m_q[i];
    end
  end

  always_comb begin
    unique case (op_q)
      OP_MUL25519: mod_v = Prime25519[N-1:0];
      OP_MULP256:  mod_v = PrimeP256[N-1:0];
      default:     mod_v = m_v;
    endcase
  end

  assign s_axis_tready = (st_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        a_q[i] <= '0;
        b_q[i] <= '0;
        m_q[i] <= '0;
      end
    end else if (accept && kind != KIND_EXEC && {1'b0, lidx} < 3'(NLimb)) begin
      unique case (kind)
        KIND_LOAD_A: a_q[lidx] <= s_axis_tdata[LIMB_BITS-1:0];
        KIND_LOAD_B: b_q[lidx] <= s_axis_tdata[LIMB_BITS-1:0];
        default:     m_q[lidx] <= s_axis_tdata[LIMB_BITS-1:0];
      endcase
    end
  end

  mau_multiplier #(.OperandBits(N)) u_mul (
    .clk_i   (clk_i),
    .start_i (mstart),
    .step_i  (mstep),
    .a_i     (a_v),
    .b_i     (b_v),
    .p_o     (prod)
  );

  mau_reducer #(.OperandBits(N)) u_red (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (rctrl),
    .x_i    (rsrc),
    .m_i    (mod_v),
    .r_o    (rem)
  );

  assign fix_sum = {1'b0, ra_q} + {1'b0, mod_v} - {1'b0, rem};

  always_comb begin
    st_d   = st_q;
    op_d   = op_q;
    cnt_d  = cnt_q;
    oidx_d = oidx_q;
    err_d  = err_q;
    ra_d   = ra_q;
    res_d  = res_q;
    mstart = 1'b0;
    mstep  = 1'b0;
    rctrl  = '0;
    rsrc   = prod;
    unique case (st_q)
      ST_IDLE: begin
        if (accept && kind == KIND_EXEC && op_in <= 3'(OP_REDP)) begin
          op_d   = op_e'(op_in);
          cnt_d  = '0;
          oidx_d = '0;
          err_d  = 1'b0;
          mstart = 1'b1;
          st_d   = ST_MUL;
        end
      end
      ST_MUL: begin
        unique case (op_q)
          OP_ADDP: rsrc = {{(N-1){1'b0}}, {1'b0, a_v} + {1'b0, b_v}};
          OP_SUBP: rsrc = {{N{1'b0}}, a_v};
          OP_REDP: rsrc = {a_v, b_v};
          default: rsrc = prod;
        endcase
        if (mod_v == '0) begin
          err_d = 1'b1;
          res_d = '0;
          st_d  = ST_EMIT;
        end else if (op_q == OP_ADDP || op_q == OP_SUBP || op_q == OP_REDP
                     || cnt_q == CntW'(N)) begin
          rctrl.start = 1'b1;
          cnt_d       = '0;
          st_d        = ST_RED;
        end else begin
          mstep = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_RED: begin
        if (cnt_q == CntW'(2*N)) begin
          cnt_d = '0;
          if (op_q == OP_SUBP) begin
            ra_d        = rem;
            rsrc        = {{N{1'b0}}, b_v};
            rctrl.start = 1'b1;
            st_d        = ST_RED2;
          end else begin
            res_d = rem;
            st_d  = ST_EMIT;
          end
        end else begin
          rctrl.step = 1'b1;
          cnt_d      = cnt_q + 1'b1;
        end
      end
      ST_RED2: begin
        if (cnt_q == CntW'(2*N)) begin
          st_d = ST_FIX;
        end else begin
          rctrl.step = 1'b1;
          cnt_d      = cnt_q + 1'b1;
        end
      end
      ST_FIX: begin
        // add the modulus back when the difference goes negative
        res_d = (ra_q < rem) ? fix_sum[N-1:0] : ra_q - rem;
        st_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (m_axis_tready) begin
          oidx_d = oidx_q + 1'b1;
          if ({1'b0, oidx_q} == 3'(NLimb - 1)) begin
            st_d = ST_IDLE;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      op_q   <= OP_MUL25519;
      cnt_q  <= '0;
      oidx_q <= '0;
      err_q  <= 1'b0;
    end else begin
      st_q   <= st_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
      oidx_q <= oidx_d;
      err_q  <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q  <= ra_d;
    res_q <= res_d;
  end

  logic [63:0] out_limb;
  assign out_limb      = 64'(res_q[oidx_q * LIMB_BITS +: LIMB_BITS]);
  assign m_axis_tvalid = (st_q == ST_EMIT);
  assign m_axis_tdata  = {6'b0, oidx_q, out_limb};
  assign m_axis_tlast  = ({1'b0, oidx_q} == 3'(NLimb - 1));
  assign m_axis_tuser  = err_q;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid) else $error("input ready while emitting");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> st_q == ST_IDLE)
    else $error("run did not end on last word");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[63:0] == 64'd0)
    else $error("error result not zero");
`endif

endmodule
